FILE: rtl/pfp_pkg.sv
// shared widths, word types and stage records for the plane coefficient unit
// no dependencies
package pfp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int EW          = COORD_WIDTH + 1;
  localparam int MW          = 2 * EW;
  localparam int HW          = MW / 2;
  localparam int NW          = MW + 1;
  localparam int SW          = 2 * MW;
  localparam int COEF_FRAC   = 30;
  localparam int SCALE_SHIFT = 2 * COEF_FRAC + 2;
  localparam int QW          = SCALE_SHIFT + 1;
  localparam int NSQ         = (QW + 1) / 2;
  localparam int TW          = QW + 1;
  localparam int QOW         = COEF_FRAC + 1;
  localparam int FW          = 32;
  localparam int PRW         = FW + COORD_WIDTH;
  localparam int AW          = PRW + 2;

  typedef struct packed {
    logic                          op;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;
  } in_word_t;

  typedef struct packed {
    logic signed [FW-1:0] coef_a;
    logic signed [FW-1:0] coef_b;
    logic signed [FW-1:0] coef_c;
    logic signed [FW-1:0] coef_d;
    logic                 degenerate;
  } out_word_t;

  typedef struct packed {
    logic [2:0][SW-1:0]          sq;
    logic [SW-1:0]               sum;
    logic [2:0]                  neg;
    logic [2:0][COORD_WIDTH-1:0] p0;
  } front_t;

  typedef struct packed {
    logic [2:0]                  neg;
    logic [2:0][COORD_WIDTH-1:0] p0;
    logic                        degen;
  } side_t;

  typedef struct packed {
    logic [2:0][QOW-1:0] q;
    side_t               side;
  } root_t;

endpackage

FILE: rtl/pfp_front.sv
// front pipeline: edges, cross product or the given normal, magnitudes and squared length
// depends on pfp_pkg
module pfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  pfp_pkg::in_word_t in_word,
  output logic              out_vld,
  output pfp_pkg::front_t   out_front
);

  localparam int CW = pfp_pkg::COORD_WIDTH;
  localparam int EW = pfp_pkg::EW;
  localparam int MW = pfp_pkg::MW;
  localparam int HW = pfp_pkg::HW;
  localparam int NW = pfp_pkg::NW;
  localparam int SW = pfp_pkg::SW;
  localparam int NST = 7;

  logic [NST-1:0] vld_r;

  logic [2:0][CW-1:0] p0, p1, p2;
  logic [2:0][EW-1:0] e1_nxt, e2_nxt;

  logic               op_s1_r, op_s2_r;
  logic [2:0][CW-1:0] p0_s1_r, p0_s2_r, p0_s3_r, p0_s4_r, p0_s5_r, p0_s6_r, p0_s7_r;
  logic [2:0][CW-1:0] p1_s1_r, p1_s2_r;
  logic [2:0][EW-1:0] e1_s1_r, e2_s1_r;
  logic [2:0][MW-1:0] pa_nxt, pb_nxt, pa_s2_r, pb_s2_r;
  logic [2:0][NW-1:0] n_nxt, n_s3_r, abs_n;
  logic [2:0][MW-1:0] m_s4_r;
  logic [2:0]         neg_s4_r, neg_s5_r, neg_s6_r, neg_s7_r;
  logic [2:0][MW-1:0] hh_nxt, hl_nxt, ll_nxt, hh_s5_r, hl_s5_r, ll_s5_r;
  logic [2:0][SW-1:0] sq_nxt, sq_s6_r, sq_s7_r;
  logic [SW-1:0]      sum_s7_r;

  always_comb begin
    p0[0] = in_word.first_x;  p0[1] = in_word.first_y;  p0[2] = in_word.first_z;
    p1[0] = in_word.second_x; p1[1] = in_word.second_y; p1[2] = in_word.second_z;
    p2[0] = in_word.third_x;  p2[1] = in_word.third_y;  p2[2] = in_word.third_z;
    for (int k = 0; k < 3; k++) begin
      e1_nxt[k] = $signed({p1[k][CW-1], p1[k]}) - $signed({p0[k][CW-1], p0[k]});
      e2_nxt[k] = $signed({p2[k][CW-1], p2[k]}) - $signed({p0[k][CW-1], p0[k]});
    end
  end

  // cross product terms
  always_comb begin
    pa_nxt[0] = $signed(e1_s1_r[1]) * $signed(e2_s1_r[2]);
    pb_nxt[0] = $signed(e1_s1_r[2]) * $signed(e2_s1_r[1]);
    pa_nxt[1] = $signed(e1_s1_r[2]) * $signed(e2_s1_r[0]);
    pb_nxt[1] = $signed(e1_s1_r[0]) * $signed(e2_s1_r[2]);
    pa_nxt[2] = $signed(e1_s1_r[0]) * $signed(e2_s1_r[1]);
    pb_nxt[2] = $signed(e1_s1_r[1]) * $signed(e2_s1_r[0]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (op_s2_r) begin
        n_nxt[k] = $signed(p1_s2_r[k]);
      end else begin
        n_nxt[k] = $signed(pa_s2_r[k]) - $signed(pb_s2_r[k]);
      end
      abs_n[k] = n_s3_r[k][NW-1] ? (~n_s3_r[k] + 1'b1) : n_s3_r[k];
    end
  end

  // squares from half-width partial products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hh_nxt[k] = m_s4_r[k][MW-1:HW] * m_s4_r[k][MW-1:HW];
      hl_nxt[k] = m_s4_r[k][MW-1:HW] * m_s4_r[k][HW-1:0];
      ll_nxt[k] = m_s4_r[k][HW-1:0] * m_s4_r[k][HW-1:0];
      sq_nxt[k] = (SW'(hh_s5_r[k]) << MW) + (SW'(hl_s5_r[k]) << (HW + 1)) + SW'(ll_s5_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_s1_r  <= in_word.op;
      p0_s1_r  <= p0;
      p1_s1_r  <= p1;
      e1_s1_r  <= e1_nxt;
      e2_s1_r  <= e2_nxt;
      op_s2_r  <= op_s1_r;
      p0_s2_r  <= p0_s1_r;
      p1_s2_r  <= p1_s1_r;
      pa_s2_r  <= pa_nxt;
      pb_s2_r  <= pb_nxt;
      p0_s3_r  <= p0_s2_r;
      n_s3_r   <= n_nxt;
      p0_s4_r  <= p0_s3_r;
      for (int k = 0; k < 3; k++) begin
        m_s4_r[k]   <= abs_n[k][MW-1:0];
        neg_s4_r[k] <= n_s3_r[k][NW-1];
      end
      p0_s5_r  <= p0_s4_r;
      neg_s5_r <= neg_s4_r;
      hh_s5_r  <= hh_nxt;
      hl_s5_r  <= hl_nxt;
      ll_s5_r  <= ll_nxt;
      p0_s6_r  <= p0_s5_r;
      neg_s6_r <= neg_s5_r;
      sq_s6_r  <= sq_nxt;
      p0_s7_r  <= p0_s6_r;
      neg_s7_r <= neg_s6_r;
      sq_s7_r  <= sq_s6_r;
      sum_s7_r <= sq_s6_r[0] + sq_s6_r[1] + sq_s6_r[2];
    end
  end

  assign out_vld        = vld_r[NST-1];
  assign out_front.sq   = sq_s7_r;
  assign out_front.sum  = sum_s7_r;
  assign out_front.neg  = neg_s7_r;
  assign out_front.p0   = p0_s7_r;

endmodule

FILE: rtl/pfp_root.sv
// pipelined restoring divider and integer square root, one bit per stage per lane
// depends on pfp_pkg
module pfp_root (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  pfp_pkg::front_t in_front,
  output logic            out_vld,
  output pfp_pkg::root_t  out_root
);

  localparam int SW  = pfp_pkg::SW;
  localparam int QW  = pfp_pkg::QW;
  localparam int NSQ = pfp_pkg::NSQ;
  localparam int TW  = pfp_pkg::TW;
  localparam int QOW = pfp_pkg::QOW;
  localparam int NP  = QW + NSQ;

  logic [NP-1:0]      vld_r;
  pfp_pkg::side_t     side_r [NP];
  pfp_pkg::side_t     side_in;
  logic [2:0][SW-1:0] rem_r [QW-1];
  logic [SW-1:0]      den_r [QW-1];
  logic [2:0][QW-1:0] quo_r [QW];
  logic [2:0][QW-1:0] num_r [NSQ-1];
  logic [2:0][TW-1:0] res_r [NSQ];

  always_comb begin
    side_in.neg   = in_front.neg;
    side_in.p0    = in_front.p0;
    side_in.degen = (in_front.sum == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NP-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < NP; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // quotient of squared component over squared length, scaled
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][SW:0]   t, dif;
    logic [2:0][SW-1:0] r_nxt;
    logic [2:0][QW-1:0] q_prev, q_nxt;
    logic [2:0]         ge;
    logic [SW-1:0]      den;

    if (j == 0) begin : g_head
      always_comb begin
        den = in_front.sum;
        for (int k = 0; k < 3; k++) begin
          t[k]      = {1'b0, in_front.sq[k]};
          q_prev[k] = '0;
        end
      end
    end else begin : g_body
      always_comb begin
        den = den_r[j-1];
        for (int k = 0; k < 3; k++) begin
          t[k] = {rem_r[j-1][k], 1'b0};
        end
        q_prev = quo_r[j-1];
      end
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        dif[k]   = t[k] - {1'b0, den};
        ge[k]    = (t[k] >= {1'b0, den});
        r_nxt[k] = ge[k] ? dif[k][SW-1:0] : t[k][SW-1:0];
        q_nxt[k] = {q_prev[k][QW-2:0], ge[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j] <= q_nxt;
      end
    end

    if (j < QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= r_nxt;
          den_r[j] <= den;
        end
      end
    end
  end

  // integer square root, one result bit per stage
  for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
    localparam logic [TW-1:0] ONE = TW'(1) << (2 * (NSQ - 1 - s));
    logic [2:0][QW-1:0] n_prev, n_nxt;
    logic [2:0][TW-1:0] r_prev, r_nxt, trial;
    logic [2:0]         ge;

    if (s == 0) begin : g_head
      always_comb begin
        n_prev = quo_r[QW-1];
        r_prev = '0;
      end
    end else begin : g_body
      always_comb begin
        n_prev = num_r[s-1];
        r_prev = res_r[s-1];
      end
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = r_prev[k] + ONE;
        ge[k]    = ({1'b0, n_prev[k]} >= trial[k]);
        n_nxt[k] = ge[k] ? (n_prev[k] - trial[k][QW-1:0]) : n_prev[k];
        r_nxt[k] = ge[k] ? ((r_prev[k] >> 1) + ONE) : (r_prev[k] >> 1);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[s] <= r_nxt;
      end
    end

    if (s < NSQ - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[s] <= n_nxt;
        end
      end
    end
  end

  // largest odd bound halves into the rounded coefficient
  logic [2:0][TW-1:0] u_inc;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_inc[k]       = res_r[NSQ-1][k] + TW'(1);
      out_root.q[k]  = u_inc[k][QOW:1];
    end
    out_root.side = side_r[NP-1];
  end

  assign out_vld = vld_r[NP-1];

endmodule

FILE: rtl/pfp_back.sv
// back pipeline: signed coefficients, offset dot product, rounding and saturation
// depends on pfp_pkg
module pfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  pfp_pkg::root_t     in_root,
  output logic               out_vld,
  output pfp_pkg::out_word_t out_word
);

  localparam int CW  = pfp_pkg::COORD_WIDTH;
  localparam int FW  = pfp_pkg::FW;
  localparam int PRW = pfp_pkg::PRW;
  localparam int AW  = pfp_pkg::AW;
  localparam int CF  = pfp_pkg::COEF_FRAC;
  localparam int NST = 5;

  logic [NST-1:0] vld_r;

  logic [2:0][FW-1:0]  coef_nxt, coef_s1_r, coef_s2_r, coef_s3_r, coef_s4_r;
  logic [2:0][CW-1:0]  p0_s1_r;
  logic                dg_s1_r, dg_s2_r, dg_s3_r, dg_s4_r;
  logic [2:0][PRW-1:0] prod_nxt, prod_s2_r;
  logic [AW-1:0]       acc_nxt, acc_s3_r;
  logic [AW-1:0]       mag_s4_r;
  logic                dneg_s4_r;
  logic [AW:0]         rsum, rnd, lim, low;
  logic [FW-1:0]       lo, d;
  pfp_pkg::out_word_t  word_nxt, word_s5_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      coef_nxt[k] = in_root.side.neg[k] ? (~FW'(in_root.q[k]) + 1'b1) : FW'(in_root.q[k]);
      prod_nxt[k] = $signed(coef_s1_r[k]) * $signed(p0_s1_r[k]);
    end
    acc_nxt = $signed(prod_s2_r[0]) + $signed(prod_s2_r[1]) + $signed(prod_s2_r[2]);
  end

  // offset is minus the dot product, rounded half away from zero
  always_comb begin
    rsum = {1'b0, mag_s4_r} + ((AW + 1)'(1) << (CF - 1));
    rnd  = rsum >> CF;
    lim  = ((AW + 1)'(1) << (FW - 1)) - (AW + 1)'(!dneg_s4_r);
    low  = (rnd > lim) ? lim : rnd;
    lo   = low[FW-1:0];
    d    = dneg_s4_r ? (~lo + 1'b1) : lo;
    if (dg_s4_r) begin
      word_nxt.coef_a     = '0;
      word_nxt.coef_b     = '0;
      word_nxt.coef_c     = '0;
      word_nxt.coef_d     = '0;
      word_nxt.degenerate = 1'b1;
    end else begin
      word_nxt.coef_a     = coef_s4_r[0];
      word_nxt.coef_b     = coef_s4_r[1];
      word_nxt.coef_c     = coef_s4_r[2];
      word_nxt.coef_d     = d;
      word_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_s1_r <= coef_nxt;
      p0_s1_r   <= in_root.side.p0;
      dg_s1_r   <= in_root.side.degen;
      coef_s2_r <= coef_s1_r;
      dg_s2_r   <= dg_s1_r;
      prod_s2_r <= prod_nxt;
      coef_s3_r <= coef_s2_r;
      dg_s3_r   <= dg_s2_r;
      acc_s3_r  <= acc_nxt;
      coef_s4_r <= coef_s3_r;
      dg_s4_r   <= dg_s3_r;
      mag_s4_r  <= acc_s3_r[AW-1] ? (~acc_s3_r + 1'b1) : acc_s3_r;
      dneg_s4_r <= !acc_s3_r[AW-1] && (acc_s3_r != '0);
      word_s5_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_word = word_s5_r;

endmodule

FILE: rtl/plane_from_points_unit.sv
// plane coefficients from three points or from a normal and a point
// depends on pfp_pkg, pfp_front, pfp_root, pfp_back
//
//   channel | ports                          | word
//   input   | in_valid, in_stall, in_word    | pfp_pkg::in_word_t
//   result  | out_valid, out_stall, out_word | pfp_pkg::out_word_t
//
// one word per cycle while in_stall is low; a result passes the front pipeline, the
// divider (63 stages), square root (32 stages), one bit each, back end and buffer
// reset clears all valid bits and the output buffer; no clearing pass
// a two-entry output buffer keeps input flowing while one result waits;
// the whole pipeline holds only while both entries are full
module plane_from_points_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output pfp_pkg::out_word_t out_word
);

  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_ONE   = 2'd1;
  localparam logic [1:0] BUF_FULL  = 2'd2;

  logic               en;
  logic               fr_vld, rt_vld, bk_vld;
  pfp_pkg::front_t    fr_front;
  pfp_pkg::root_t     rt_root;
  pfp_pkg::out_word_t bk_word;

  logic [1:0]         cnt_r, cnt_nxt;
  pfp_pkg::out_word_t buf0_r, buf0_nxt, buf1_r, buf1_nxt;
  logic               push, pop;

  assign en       = (cnt_r != BUF_FULL);
  assign in_stall = !en;

  pfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_word  (in_word),
    .out_vld  (fr_vld),
    .out_front(fr_front)
  );

  pfp_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_front (fr_front),
    .out_vld  (rt_vld),
    .out_root (rt_root)
  );

  pfp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (rt_vld),
    .in_root  (rt_root),
    .out_vld  (bk_vld),
    .out_word (bk_word)
  );

  assign push = en && bk_vld;
  assign pop  = (cnt_r != BUF_EMPTY) && !out_stall;

  always_comb begin
    buf0_nxt = buf0_r;
    buf1_nxt = buf1_r;
    cnt_nxt  = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == BUF_EMPTY) begin
          buf0_nxt = bk_word;
        end else begin
          buf1_nxt = bk_word;
        end
        cnt_nxt = cnt_r + BUF_ONE;
      end
      2'b01: begin
        buf0_nxt = buf1_r;
        cnt_nxt  = cnt_r - BUF_ONE;
      end
      2'b11: begin
        buf0_nxt = bk_word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= BUF_EMPTY;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf0_r <= buf0_nxt;
    buf1_r <= buf1_nxt;
  end

  assign out_valid = (cnt_r != BUF_EMPTY);
  assign out_word  = buf0_r;

endmodule

FILE: rtl/pfp_checker.sv
// port-level checks for the plane coefficient unit, bound to the top level
// depends on pfp_pkg and plane_from_points_unit
module pfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pfp_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input pfp_pkg::out_word_t out_word
);

  localparam logic signed [31:0] UNIT_POS = 32'sd1073741824;
  localparam logic signed [31:0] UNIT_NEG = -32'sd1073741824;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.degenerate |->
      out_word.coef_a == '0 && out_word.coef_b == '0 &&
      out_word.coef_c == '0 && out_word.coef_d == '0)
    else $error("degenerate word with nonzero coefficients");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_word.coef_a <= UNIT_POS && out_word.coef_a >= UNIT_NEG &&
      out_word.coef_b <= UNIT_POS && out_word.coef_b >= UNIT_NEG &&
      out_word.coef_c <= UNIT_POS && out_word.coef_c >= UNIT_NEG)
    else $error("normal component out of unit range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("unit not empty after reset");

endmodule

bind plane_from_points_unit pfp_checker u_pfp_checker (.*);
